// ----- rtl/core/bmp8_pkg.sv -----
// bmp8_pkg: constants and types for the 8 bpp indexed bitmap decoder
// header byte positions, field codes, result kinds and size limits
// no dependencies
`default_nettype none

package bmp8_pkg;

    // size limits
    localparam int unsigned MAX_DIM     = 4096;
    localparam int unsigned PAL_ENTRIES = 256;
    localparam int unsigned PAL_AW      = $clog2(PAL_ENTRIES);

    // header layout (little-endian fields)
    localparam int unsigned HDR_LEN        = 54;
    localparam logic [5:0]  HDR_SIG_POS    = 6'd0;
    localparam logic [5:0]  HDR_OFF_POS    = 6'd10;
    localparam logic [5:0]  HDR_INFO_POS   = 6'd14;
    localparam logic [5:0]  HDR_W_POS      = 6'd18;
    localparam logic [5:0]  HDR_H_POS      = 6'd22;
    localparam logic [5:0]  HDR_PLANES_POS = 6'd26;
    localparam logic [5:0]  HDR_BPP_POS    = 6'd28;
    localparam logic [5:0]  HDR_COMP_POS   = 6'd30;
    localparam logic [5:0]  HDR_COUNT_POS  = 6'd46;
    localparam logic [5:0]  HDR_LAST_POS   = 6'(HDR_LEN - 1);

    // expected header values
    localparam logic [7:0]  SIG_B       = 8'h42;
    localparam logic [7:0]  SIG_M       = 8'h4D;
    localparam logic [31:0] INFO_SIZE   = 32'd40;
    localparam logic [15:0] PLANES_ONE  = 16'd1;
    localparam logic [15:0] BPP_EIGHT   = 16'd8;
    localparam logic [31:0] COMP_NONE   = 32'd0;

    // result kinds
    typedef enum logic [1:0] {
        KIND_PIXEL  = 2'd0,
        KIND_ACCEPT = 2'd1,
        KIND_REJECT = 2'd2
    } kind_t;

endpackage

`default_nettype wire

// ----- rtl/core/bmp_8bit_palette_decoder_core.sv -----
// bmp_8bit_palette_decoder_core: byte-stream decoder for uncompressed 8 bpp indexed bitmaps
// parses and checks the header, loads the palette, emits one result per pixel index byte
// depends on bmp8_pkg
//
// path: a result moves from the input stage register into the result register on m_*
// throughput: one file byte per cycle unless stalled; an input register stage with the
//   palette read and the result register part the two sides, so s_ready stays high
//   while a finished result waits, as long as the input stage is free to move
// palette: a 256 x 24 memory, one write and one registered read per cycle; entries
//   not written in the current file read as zero through per-entry valid bits
// reset: aresetn synchronous, active low; parser idle, all counters and valid bits
//   cleared, no result pending; the first beat with s_start_of_file opens a file
`default_nettype none

module bmp_8bit_palette_decoder_core
    import bmp8_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,

    // file byte stream
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_file_byte,
    input  wire logic        s_start_of_file,

    // result stream
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [1:0]       m_kind,
    output logic [7:0]       m_blue,
    output logic [7:0]       m_green,
    output logic [7:0]       m_red,
    output logic [11:0]      m_row,
    output logic [11:0]      m_column,
    output logic [12:0]      m_image_width,
    output logic [12:0]      m_image_height,
    output logic             m_last
);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_HEADER,
        PH_PALETTE,
        PH_SKIP,
        PH_PIXELS,
        PH_DONE
    } phase_t;

    // ------------------------------------------------------------------
    // control state
    // ------------------------------------------------------------------
    phase_t                 phase_reg;
    logic [31:0]            byte_pos_reg;
    logic [PAL_AW+1:0]      pal_rel_reg;      // byte count inside the palette
    logic [PAL_AW:0]        colors_reg;
    logic [12:0]            width_reg;
    logic [12:0]            height_reg;
    logic [12:0]            stride_reg;
    logic                   bottom_up_reg;
    logic [31:0]            data_off_reg;
    logic [11:0]            cur_row_reg;
    logic [12:0]            bir_reg;          // byte within the current row
    logic [PAL_ENTRIES-1:0] pal_valid_reg;

    // header fields, filled byte by byte
    logic [15:0]            sig_reg;
    logic [31:0]            off_raw_reg;
    logic [31:0]            info_reg;
    logic [31:0]            w_raw_reg;
    logic [31:0]            h_raw_reg;
    logic [15:0]            planes_reg;
    logic [15:0]            bpp_reg;
    logic [31:0]            comp_reg;
    logic [31:0]            count_raw_reg;

    // partial palette entry (blue, green) until red arrives
    logic [7:0]             pal_b0_reg;
    logic [7:0]             pal_b1_reg;
    logic [23:0]            pal_mem [PAL_ENTRIES];

    // input stage
    logic                   s1_valid_reg;
    kind_t                  s1_kind_reg;
    logic [11:0]            s1_row_reg;
    logic [11:0]            s1_col_reg;
    logic [12:0]            s1_w_reg;
    logic [12:0]            s1_h_reg;
    logic                   s1_last_reg;
    logic                   s1_hit_reg;
    logic [23:0]            pal_rdata_reg;

    // result register
    logic                   m_valid_reg;
    kind_t                  m_kind_reg;
    logic [7:0]             m_blue_reg;
    logic [7:0]             m_green_reg;
    logic [7:0]             m_red_reg;
    logic [11:0]            m_row_reg;
    logic [11:0]            m_col_reg;
    logic [12:0]            m_w_reg;
    logic [12:0]            m_h_reg;
    logic                   m_last_reg;

    // ------------------------------------------------------------------
    // handshake: the input stage moves on when the result register is free
    // ------------------------------------------------------------------
    logic in_accept;
    logic m_load;

    assign m_load    = s1_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready   = !s1_valid_reg || m_load;
    assign in_accept = s_valid && s_ready;

    // a file start overrides whatever the parser was doing
    phase_t      eff_phase;
    logic [31:0] eff_pos;
    logic [31:0] pos_inc;
    logic [5:0]  hdr_idx;

    assign eff_phase = s_start_of_file ? PH_HEADER : phase_reg;
    assign eff_pos   = s_start_of_file ? 32'd0 : byte_pos_reg;
    assign pos_inc   = eff_pos + 32'd1;
    assign hdr_idx   = eff_pos[5:0];   // header phase never passes the last header byte

    // ------------------------------------------------------------------
    // header check, evaluated on the last header byte
    // ------------------------------------------------------------------
    logic [31:0] count_eff;
    logic [31:0] h_abs;
    logic [33:0] pal_end;
    logic [12:0] stride_calc;
    logic [12:0] w_round;
    logic        hdr_ok;

    assign count_eff = (count_raw_reg == 32'd0) ? 32'(PAL_ENTRIES) : count_raw_reg;
    assign h_abs     = h_raw_reg[31] ? (32'd0 - h_raw_reg) : h_raw_reg;
    assign pal_end   = 34'(HDR_LEN) + {count_eff, 2'b00};
    // stride of one byte per pixel rounded up to whole 32-bit words
    assign w_round     = w_raw_reg[12:0] + 13'd3;
    assign stride_calc = {w_round[12:2], 2'b00};

    always_comb begin
        hdr_ok = 1'b1;
        if (sig_reg != {SIG_M, SIG_B})                             hdr_ok = 1'b0;
        if (info_reg != INFO_SIZE)                                 hdr_ok = 1'b0;
        if (w_raw_reg[31] || w_raw_reg == 32'd0 || w_raw_reg > 32'(MAX_DIM))
            hdr_ok = 1'b0;
        if (h_raw_reg == 32'd0 || h_abs > 32'(MAX_DIM))            hdr_ok = 1'b0;
        if (planes_reg != PLANES_ONE || bpp_reg != BPP_EIGHT)      hdr_ok = 1'b0;
        if (comp_reg != COMP_NONE)                                 hdr_ok = 1'b0;
        if (count_eff > 32'(PAL_ENTRIES))                          hdr_ok = 1'b0;
        // data must not start inside the palette
        if ({2'b00, data_off_raw()} < pal_end)                     hdr_ok = 1'b0;
    end

    function automatic logic [31:0] data_off_raw();
        return off_raw_reg;
    endfunction

    // ------------------------------------------------------------------
    // palette load
    // ------------------------------------------------------------------
    logic [PAL_AW-1:0] pal_idx;
    logic [1:0]        pal_part;
    logic              pal_last_byte;
    logic              pal_we;

    assign pal_idx       = pal_rel_reg[PAL_AW+1:2];
    assign pal_part      = pal_rel_reg[1:0];
    assign pal_last_byte = (pal_part == 2'd3)
                        && ({1'b0, pal_idx} == (colors_reg - (PAL_AW+1)'(1)));
    // an entry is written whole once its red byte arrives; the pad byte is dropped
    assign pal_we        = in_accept && (eff_phase == PH_PALETTE) && (pal_part == 2'd2);

    // ------------------------------------------------------------------
    // pixel walk
    // ------------------------------------------------------------------
    logic        pix_emit;
    logic        pix_last;
    logic [11:0] pix_row;
    logic [12:0] bir_inc;
    logic        row_wrap;

    assign pix_emit = bir_reg < width_reg;
    assign bir_inc  = bir_reg + 13'd1;
    assign pix_last = (({1'b0, cur_row_reg} + 13'd1) == height_reg) && (bir_inc == width_reg);
    assign pix_row  = bottom_up_reg ? 12'(height_reg - 13'd1 - {1'b0, cur_row_reg})
                                    : cur_row_reg;
    assign row_wrap = bir_inc >= stride_reg;

    // ------------------------------------------------------------------
    // result of the current beat
    // ------------------------------------------------------------------
    logic        res_valid;
    kind_t       res_kind;
    logic [11:0] res_row;
    logic [11:0] res_col;
    logic [12:0] res_w;
    logic [12:0] res_h;
    logic        res_last;
    logic        res_pix;

    always_comb begin
        res_valid = 1'b0;
        res_kind  = KIND_PIXEL;
        res_row   = '0;
        res_col   = '0;
        res_w     = '0;
        res_h     = '0;
        res_last  = 1'b0;
        res_pix   = 1'b0;
        unique case (eff_phase)
            PH_HEADER: begin
                if (hdr_idx == HDR_LAST_POS) begin
                    res_valid = 1'b1;
                    if (hdr_ok) begin
                        res_kind = KIND_ACCEPT;
                        res_w    = w_raw_reg[12:0];
                        res_h    = h_abs[12:0];
                    end else begin
                        res_kind = KIND_REJECT;
                    end
                end
            end
            PH_PIXELS: begin
                if (pix_emit) begin
                    res_valid = 1'b1;
                    res_pix   = 1'b1;
                    res_row   = pix_row;
                    res_col   = bir_reg[11:0];
                    res_last  = pix_last;
                end
            end
            default: begin
            end
        endcase
    end

    // ------------------------------------------------------------------
    // parser state and stage valids
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_IDLE;
            byte_pos_reg  <= '0;
            pal_rel_reg   <= '0;
            colors_reg    <= '0;
            width_reg     <= '0;
            height_reg    <= '0;
            stride_reg    <= '0;
            bottom_up_reg <= 1'b0;
            data_off_reg  <= '0;
            cur_row_reg   <= '0;
            bir_reg       <= '0;
            pal_valid_reg <= '0;
            s1_valid_reg  <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (m_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end

            if (in_accept) begin
                s1_valid_reg <= res_valid;
            end else if (m_load) begin
                s1_valid_reg <= 1'b0;
            end

            if (in_accept) begin
                if (s_start_of_file) begin
                    pal_valid_reg <= '0;
                end
                if (pal_we) begin
                    pal_valid_reg[pal_idx] <= 1'b1;
                end

                unique case (eff_phase)
                    PH_HEADER: begin
                        byte_pos_reg <= pos_inc;
                        if (hdr_idx == HDR_LAST_POS) begin
                            if (hdr_ok) begin
                                width_reg     <= w_raw_reg[12:0];
                                height_reg    <= h_abs[12:0];
                                bottom_up_reg <= !h_raw_reg[31];
                                stride_reg    <= stride_calc;
                                colors_reg    <= count_eff[PAL_AW:0];
                                data_off_reg  <= off_raw_reg;
                                cur_row_reg   <= '0;
                                bir_reg       <= '0;
                                pal_rel_reg   <= '0;
                                phase_reg     <= PH_PALETTE;
                            end else begin
                                phase_reg     <= PH_IDLE;
                            end
                        end else begin
                            phase_reg <= PH_HEADER;
                        end
                    end
                    PH_PALETTE: begin
                        byte_pos_reg <= pos_inc;
                        pal_rel_reg  <= pal_rel_reg + (PAL_AW+2)'(1);
                        if (pal_last_byte) begin
                            phase_reg <= (pos_inc == data_off_reg) ? PH_PIXELS : PH_SKIP;
                        end
                    end
                    PH_SKIP: begin
                        byte_pos_reg <= pos_inc;
                        if (pos_inc == data_off_reg) begin
                            phase_reg <= PH_PIXELS;
                        end
                    end
                    PH_PIXELS: begin
                        byte_pos_reg <= pos_inc;
                        if (pix_emit && pix_last) begin
                            phase_reg <= PH_DONE;
                        end else if (row_wrap) begin
                            bir_reg     <= '0;
                            cur_row_reg <= cur_row_reg + 12'd1;
                        end else begin
                            bir_reg <= bir_inc;
                        end
                    end
                    default: begin
                        // idle or past the image: bytes are dropped
                    end
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // header field capture
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (in_accept && eff_phase == PH_HEADER) begin
            unique case (hdr_idx)
                HDR_SIG_POS:                sig_reg[7:0]         <= s_file_byte;
                HDR_SIG_POS + 6'd1:         sig_reg[15:8]        <= s_file_byte;
                HDR_OFF_POS:                off_raw_reg[7:0]     <= s_file_byte;
                HDR_OFF_POS + 6'd1:         off_raw_reg[15:8]    <= s_file_byte;
                HDR_OFF_POS + 6'd2:         off_raw_reg[23:16]   <= s_file_byte;
                HDR_OFF_POS + 6'd3:         off_raw_reg[31:24]   <= s_file_byte;
                HDR_INFO_POS:               info_reg[7:0]        <= s_file_byte;
                HDR_INFO_POS + 6'd1:        info_reg[15:8]       <= s_file_byte;
                HDR_INFO_POS + 6'd2:        info_reg[23:16]      <= s_file_byte;
                HDR_INFO_POS + 6'd3:        info_reg[31:24]      <= s_file_byte;
                HDR_W_POS:                  w_raw_reg[7:0]       <= s_file_byte;
                HDR_W_POS + 6'd1:           w_raw_reg[15:8]      <= s_file_byte;
                HDR_W_POS + 6'd2:           w_raw_reg[23:16]     <= s_file_byte;
                HDR_W_POS + 6'd3:           w_raw_reg[31:24]     <= s_file_byte;
                HDR_H_POS:                  h_raw_reg[7:0]       <= s_file_byte;
                HDR_H_POS + 6'd1:           h_raw_reg[15:8]      <= s_file_byte;
                HDR_H_POS + 6'd2:           h_raw_reg[23:16]     <= s_file_byte;
                HDR_H_POS + 6'd3:           h_raw_reg[31:24]     <= s_file_byte;
                HDR_PLANES_POS:             planes_reg[7:0]      <= s_file_byte;
                HDR_PLANES_POS + 6'd1:      planes_reg[15:8]     <= s_file_byte;
                HDR_BPP_POS:                bpp_reg[7:0]         <= s_file_byte;
                HDR_BPP_POS + 6'd1:         bpp_reg[15:8]        <= s_file_byte;
                HDR_COMP_POS:               comp_reg[7:0]        <= s_file_byte;
                HDR_COMP_POS + 6'd1:        comp_reg[15:8]       <= s_file_byte;
                HDR_COMP_POS + 6'd2:        comp_reg[23:16]      <= s_file_byte;
                HDR_COMP_POS + 6'd3:        comp_reg[31:24]      <= s_file_byte;
                HDR_COUNT_POS:              count_raw_reg[7:0]   <= s_file_byte;
                HDR_COUNT_POS + 6'd1:       count_raw_reg[15:8]  <= s_file_byte;
                HDR_COUNT_POS + 6'd2:       count_raw_reg[23:16] <= s_file_byte;
                HDR_COUNT_POS + 6'd3:       count_raw_reg[31:24] <= s_file_byte;
                default: begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // palette memory: entry assembled from blue, green, red bytes
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (in_accept && eff_phase == PH_PALETTE) begin
            if (pal_part == 2'd0) begin
                pal_b0_reg <= s_file_byte;
            end
            if (pal_part == 2'd1) begin
                pal_b1_reg <= s_file_byte;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pal_we) begin
            pal_mem[pal_idx] <= {s_file_byte, pal_b1_reg, pal_b0_reg};
        end
        if (in_accept) begin
            pal_rdata_reg <= pal_mem[s_file_byte[PAL_AW-1:0]];
        end
    end

    // ------------------------------------------------------------------
    // input stage register
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (in_accept) begin
            s1_kind_reg <= res_kind;
            s1_row_reg  <= res_row;
            s1_col_reg  <= res_col;
            s1_w_reg    <= res_w;
            s1_h_reg    <= res_h;
            s1_last_reg <= res_last;
            // entries not loaded in this file read as zero
            s1_hit_reg  <= res_pix && pal_valid_reg[s_file_byte[PAL_AW-1:0]];
        end
    end

    // ------------------------------------------------------------------
    // result register
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (m_load) begin
            m_kind_reg  <= s1_kind_reg;
            m_blue_reg  <= s1_hit_reg ? pal_rdata_reg[7:0]   : 8'd0;
            m_green_reg <= s1_hit_reg ? pal_rdata_reg[15:8]  : 8'd0;
            m_red_reg   <= s1_hit_reg ? pal_rdata_reg[23:16] : 8'd0;
            m_row_reg   <= s1_row_reg;
            m_col_reg   <= s1_col_reg;
            m_w_reg     <= s1_w_reg;
            m_h_reg     <= s1_h_reg;
            m_last_reg  <= s1_last_reg;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_kind         = m_kind_reg;
    assign m_blue         = m_blue_reg;
    assign m_green        = m_green_reg;
    assign m_red          = m_red_reg;
    assign m_row          = m_row_reg;
    assign m_column       = m_col_reg;
    assign m_image_width  = m_w_reg;
    assign m_image_height = m_h_reg;
    assign m_last         = m_last_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_file_start_restarts: assert property (@(posedge aclk) disable iff (!aresetn)
        in_accept && s_start_of_file |=> phase_reg == PH_HEADER && byte_pos_reg == 32'd1
            && pal_valid_reg == '0)
        else $error("file start did not restart the parser");

    a_stage_held: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_valid_reg && !m_load |=> s1_valid_reg)
        else $error("pending result dropped from input stage");

    a_pal_write_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        pal_we |-> !s_start_of_file && phase_reg == PH_PALETTE)
        else $error("palette written outside palette phase");

    a_header_no_colour: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_kind_reg != KIND_PIXEL |->
            m_blue_reg == 8'd0 && m_green_reg == 8'd0 && m_red_reg == 8'd0 && !m_last_reg)
        else $error("header result carries pixel data");

    a_pixel_no_size: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_kind_reg == KIND_PIXEL |->
            m_w_reg == 13'd0 && m_h_reg == 13'd0)
        else $error("pixel result carries image size");

endmodule

`default_nettype wire
